// ===== sv/backoff_markov_jammer_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// backoff markov jammer sequencer assertion macros
// concurrent assertion shorthands clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef BACKOFF_MARKOV_JAMMER_SEQUENCER_ASSERT_SVH
`define BACKOFF_MARKOV_JAMMER_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define BMJS_ASSERT_COMB(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMJS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bmjs_pkg.sv =====
// ----------------------------------------------------------------------------
// bmjs_pkg
// shared types and constants of the backoff markov jammer sequencer
// ----------------------------------------------------------------------------
package bmjs_pkg;

  localparam int STATE_W   = 5;
  localparam int RAND_W    = 15;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int Q15_ONE = 32768;
  localparam int Q15_TWO = 65536;

  localparam logic [CFG_IDX_W-1:0] REG_COLL_PROB  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUCC_HOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLL_HOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EIFS_GAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_HOLD  = 3'd4;

  localparam logic [CFG_W-1:0] RST_COLL_PROB = 16'd13441;
  localparam logic [CFG_W-1:0] RST_SUCC_HOLD = 16'd2332;
  localparam logic [CFG_W-1:0] RST_COLL_HOLD = 16'd836;
  localparam logic [CFG_W-1:0] RST_EIFS_GAP  = 16'd461;
  localparam logic [CFG_W-1:0] RST_SLOT_HOLD = 16'd21;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_SUCC = 2'd1;
  localparam logic [1:0] KIND_COLL = 2'd2;
  localparam logic [1:0] KIND_BOFF = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] collision_prob_q15;
    logic [CFG_W-1:0] success_hold;
    logic [CFG_W-1:0] collision_hold;
    logic [CFG_W-1:0] eifs_gap;
    logic [CFG_W-1:0] slot_hold;
  } cfg_t;

  typedef struct packed {
    logic [STATE_W-1:0] next_chain_state;
    logic               jammer_on;
    logic [CFG_W-1:0]   first_hold;
    logic               turn_off_after;
    logic [CFG_W-1:0]   second_hold;
  } res_t;

endpackage

// ===== sv/bmjs_cfg.sv =====
// ----------------------------------------------------------------------------
// bmjs_cfg
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module bmjs_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bmjs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmjs_pkg::CFG_W-1:0]      cfg_data,
  output bmjs_pkg::cfg_t                  cfg
);

  bmjs_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.collision_prob_q15 <= bmjs_pkg::RST_COLL_PROB;
      cfg_r.success_hold       <= bmjs_pkg::RST_SUCC_HOLD;
      cfg_r.collision_hold     <= bmjs_pkg::RST_COLL_HOLD;
      cfg_r.eifs_gap           <= bmjs_pkg::RST_EIFS_GAP;
      cfg_r.slot_hold          <= bmjs_pkg::RST_SLOT_HOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmjs_pkg::REG_COLL_PROB: cfg_r.collision_prob_q15 <= cfg_data;
        bmjs_pkg::REG_SUCC_HOLD: cfg_r.success_hold       <= cfg_data;
        bmjs_pkg::REG_COLL_HOLD: cfg_r.collision_hold     <= cfg_data;
        bmjs_pkg::REG_EIFS_GAP:  cfg_r.eifs_gap           <= cfg_data;
        bmjs_pkg::REG_SLOT_HOLD: cfg_r.slot_hold          <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/bmjs_step.sv =====
// ----------------------------------------------------------------------------
// bmjs_step
// one markov chain transition and the jammer action of the state left
// ----------------------------------------------------------------------------
module bmjs_step #(
  parameter int STAGES      = 8,
  parameter int WINDOW_BASE = 31,
  parameter int WINDOW_MAX  = 1023
) (
  input  logic [bmjs_pkg::STATE_W-1:0] cs,
  input  logic [bmjs_pkg::RAND_W-1:0]  rand_value,
  input  bmjs_pkg::cfg_t               cfg,
  output bmjs_pkg::res_t               res,
  output logic                         jammer_active_nxt
);

  localparam int DEPTH = STAGES + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [5:0] ST6  = 6'(STAGES);
  localparam logic [5:0] B0   = 6'(STAGES + 1);
  localparam logic [5:0] LAST = 6'(2 * STAGES + 1);
  localparam logic [15:0] ONE16 = 16'(bmjs_pkg::Q15_ONE);

  logic [15:0] alpha_tab [DEPTH];
  logic [15:0] beta_tab  [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_tab
    localparam longint WRAW = longint'(WINDOW_BASE) << g;
    localparam longint W    = (WRAW > longint'(WINDOW_MAX)) ? longint'(WINDOW_MAX) : WRAW;
    localparam longint WD   = (W <= 2) ? 1 : W;
    localparam longint AQ   = (W <= 2) ? bmjs_pkg::Q15_ONE : (bmjs_pkg::Q15_TWO + WD / 2) / WD;
    localparam longint AV   = (AQ > bmjs_pkg::Q15_ONE) ? bmjs_pkg::Q15_ONE : AQ;
    localparam longint WB   = W - 1;
    localparam longint WBD  = (WB <= 2) ? 1 : WB;
    localparam longint BQ   = (WB <= 2) ? bmjs_pkg::Q15_ONE :
                              (bmjs_pkg::Q15_TWO + WBD / 2) / WBD;
    localparam longint BV   = (BQ > bmjs_pkg::Q15_ONE) ? bmjs_pkg::Q15_ONE : BQ;
    assign alpha_tab[g] = 16'(AV);
    assign beta_tab[g]  = 16'(BV);
  end

  logic [5:0]       cs6, up6, bo6, nxt6;
  logic [15:0]      p_sat, q, a0, a1, bs;
  logic [31:0]      x, p1, p12, p123;
  logic [1:0]       kind;

  always_comb begin
    cs6   = {1'b0, cs};
    up6   = cs6 + 6'd1;
    bo6   = cs6 - B0;
    p_sat = (cfg.collision_prob_q15 > ONE16) ? ONE16 : cfg.collision_prob_q15;
    q     = ONE16 - p_sat;
    a0    = alpha_tab[0];
    a1    = alpha_tab[up6[IDX_W-1:0]];
    bs    = beta_tab[bo6[IDX_W-1:0]];
    x     = {2'b00, rand_value, 15'd0};
    p1    = 32'(q) * 32'(a0);
    p12   = {1'b0, q, 15'd0};
    p123  = p12 + 32'(p_sat) * 32'(a1);

    priority if (cs6 < ST6) begin
      priority if (x < p1) begin
        nxt6 = 6'd0;
        kind = bmjs_pkg::KIND_SUCC;
      end else if (x < p12) begin
        nxt6 = B0;
        kind = bmjs_pkg::KIND_SUCC;
      end else if (x < p123) begin
        nxt6 = up6;
        kind = bmjs_pkg::KIND_COLL;
      end else begin
        nxt6 = B0 + up6;
        kind = bmjs_pkg::KIND_COLL;
      end
    end else if (cs6 == ST6) begin
      nxt6 = ({1'b0, rand_value} < a0) ? 6'd0 : B0;
      kind = bmjs_pkg::KIND_COLL;
    end else if (cs6 <= LAST) begin
      nxt6 = ({1'b0, rand_value} < bs) ? bo6 : cs6;
      kind = bmjs_pkg::KIND_BOFF;
    end else begin
      nxt6 = 6'd0;
      kind = bmjs_pkg::KIND_NONE;
    end

    res.next_chain_state = nxt6[bmjs_pkg::STATE_W-1:0];
    unique case (kind)
      bmjs_pkg::KIND_SUCC: begin
        res.jammer_on      = 1'b1;
        res.first_hold     = cfg.success_hold;
        res.turn_off_after = 1'b0;
        res.second_hold    = '0;
        jammer_active_nxt  = 1'b1;
      end
      bmjs_pkg::KIND_COLL: begin
        res.jammer_on      = 1'b1;
        res.first_hold     = cfg.collision_hold;
        res.turn_off_after = 1'b1;
        res.second_hold    = cfg.eifs_gap;
        jammer_active_nxt  = 1'b0;
      end
      bmjs_pkg::KIND_BOFF: begin
        res.jammer_on      = 1'b0;
        res.first_hold     = cfg.slot_hold;
        res.turn_off_after = 1'b0;
        res.second_hold    = '0;
        jammer_active_nxt  = 1'b0;
      end
      default: begin
        res.jammer_on      = 1'b0;
        res.first_hold     = '0;
        res.turn_off_after = 1'b0;
        res.second_hold    = '0;
        jammer_active_nxt  = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/backoff_markov_jammer_sequencer.sv =====
// ----------------------------------------------------------------------------
// backoff_markov_jammer_sequencer
// steps a dcf backoff markov chain, one random beat per step, and gives the
// jammer action for the state it leaves
// ----------------------------------------------------------------------------
// result path: input register (beat and draw), then result register
// throughput: one beat per cycle unless out_stall holds the result; the chain state
//   register closes its loop through the step logic (two 16x16 multiplies, add, compares)
// reset: synchronous active low; chain returns to transmit stage 0 and the
//   configuration registers take their default values
`include "backoff_markov_jammer_sequencer_assert.svh"

module backoff_markov_jammer_sequencer #(
  parameter int STAGES      = 8,
  parameter int WINDOW_BASE = 31,
  parameter int WINDOW_MAX  = 1023
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bmjs_pkg::RAND_W-1:0]     in_rand_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bmjs_pkg::STATE_W-1:0]    out_next_chain_state,
  output logic                            out_jammer_on,
  output logic [bmjs_pkg::CFG_W-1:0]      out_first_hold,
  output logic                            out_turn_off_after,
  output logic [bmjs_pkg::CFG_W-1:0]      out_second_hold,
  input  logic                            cfg_we,
  input  logic [bmjs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmjs_pkg::CFG_W-1:0]      cfg_data
);

  bmjs_pkg::cfg_t cfg;
  bmjs_pkg::res_t res_nxt;
  bmjs_pkg::res_t res_r;

  logic                          in_vld_r;
  logic [bmjs_pkg::RAND_W-1:0]   rand_r;
  logic                          out_vld_r;
  logic [bmjs_pkg::STATE_W-1:0]  cs_r;
  logic                          jam_r;
  logic                          jam_nxt;
  logic                          out_adv;

  bmjs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bmjs_step #(
    .STAGES      (STAGES),
    .WINDOW_BASE (WINDOW_BASE),
    .WINDOW_MAX  (WINDOW_MAX)
  ) u_step (
    .cs                (cs_r),
    .rand_value        (rand_r),
    .cfg               (cfg),
    .res               (res_nxt),
    .jammer_active_nxt (jam_nxt)
  );

  assign out_adv  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cs_r      <= '0;
      jam_r     <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (out_adv) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          cs_r  <= res_nxt.next_chain_state;
          jam_r <= jam_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      rand_r <= in_rand_value;
    end
    if (out_adv && in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_next_chain_state = res_r.next_chain_state;
  assign out_jammer_on        = res_r.jammer_on;
  assign out_first_hold       = res_r.first_hold;
  assign out_turn_off_after   = res_r.turn_off_after;
  assign out_second_hold      = res_r.second_hold;

  `BMJS_ASSERT_COMB(a_stall_needs_beat, in_stall, in_vld_r, "stall without a held beat")
  `BMJS_ASSERT_COMB(a_state_tracks_out, out_vld_r, cs_r == res_r.next_chain_state, "chain state differs from shown result")
  `BMJS_ASSERT_COMB(a_jam_tracks_out, out_vld_r, jam_r == (res_r.jammer_on && !res_r.turn_off_after), "jammer activity differs from shown action")
  `BMJS_ASSERT_COMB(a_off_is_plain, out_vld_r && !res_r.jammer_on, !res_r.turn_off_after && res_r.second_hold == '0, "off action with a second hold")
  `BMJS_ASSERT_NEXT(a_out_loads, in_vld_r && out_adv, out_vld_r, "held beat not moved to result")

endmodule

// ===== bench/backoff_markov_jammer_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backoff markov jammer sequencer testbench
// drives random draws into the chain stepper and predicts every step from a
// private copy of the chain state and settings; a scoreboard matches each
// result beat against the oldest predicted step, field by field, while both
// channels idle and stall at random and the settings change between phases
// ----------------------------------------------------------------------------
module backoff_markov_jammer_sequencer_test;

  localparam int NUM_STAGES = 8;
  localparam int WIN_BASE   = 31;
  localparam int WIN_MAX    = 1023;
  localparam int BACKOFF0   = NUM_STAGES + 1;
  localparam int TOP_STATE  = 2 * NUM_STAGES + 1;
  localparam int LAT_CYCLES = 2;

  // branches of a chain step, in draw order
  localparam int PATH_ANY     = -1;
  localparam int PATH_TX      = 0;
  localparam int PATH_BO      = 1;
  localparam int PATH_TX_NEXT = 2;
  localparam int PATH_BO_NEXT = 3;

  localparam int PICK_ANY  = 0;
  localparam int PICK_LOW  = 1;
  localparam int PICK_HIGH = 2;

  class jammer_scoreboard;
    bmjs_pkg::cfg_t               cfg;
    logic [bmjs_pkg::STATE_W-1:0] chain;
    logic                         jam_active;
    bmjs_pkg::res_t               expected_steps[$];
    int                           mismatches;

    function new();
      cfg.collision_prob_q15 = bmjs_pkg::RST_COLL_PROB;
      cfg.success_hold       = bmjs_pkg::RST_SUCC_HOLD;
      cfg.collision_hold     = bmjs_pkg::RST_COLL_HOLD;
      cfg.eifs_gap           = bmjs_pkg::RST_EIFS_GAP;
      cfg.slot_hold          = bmjs_pkg::RST_SLOT_HOLD;
      chain      = '0;
      jam_active = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [bmjs_pkg::CFG_IDX_W-1:0] idx,
                            logic [bmjs_pkg::CFG_W-1:0] d);
      case (idx)
        bmjs_pkg::REG_COLL_PROB: cfg.collision_prob_q15 = d;
        bmjs_pkg::REG_SUCC_HOLD: cfg.success_hold = d;
        bmjs_pkg::REG_COLL_HOLD: cfg.collision_hold = d;
        bmjs_pkg::REG_EIFS_GAP:  cfg.eifs_gap = d;
        bmjs_pkg::REG_SLOT_HOLD: cfg.slot_hold = d;
        default: ;
      endcase
    endfunction

    function int window(int i);
      longint w;
      w = longint'(WIN_BASE) << i;
      if (w > WIN_MAX) w = WIN_MAX;
      return int'(w);
    endfunction

    function int two_over(int d);
      int q;
      if (d <= 2) return bmjs_pkg::Q15_ONE;
      q = (bmjs_pkg::Q15_TWO + d / 2) / d;
      return (q > bmjs_pkg::Q15_ONE) ? bmjs_pkg::Q15_ONE : q;
    endfunction

    function int up_div(longint x);
      return int'((x + bmjs_pkg::Q15_ONE - 1) / bmjs_pkg::Q15_ONE);
    endfunction

    // draw values where the branches of the current state begin
    function void draw_cuts(output int c[$]);
      int     s;
      int     w;
      longint p;
      longint a0;
      longint a1;
      longint p1;
      longint p12;
      longint p123;
      s = int'(chain);
      p = (cfg.collision_prob_q15 > bmjs_pkg::Q15_ONE) ? bmjs_pkg::Q15_ONE
                                                        : cfg.collision_prob_q15;
      c = {0};
      if (s < NUM_STAGES) begin
        a0   = two_over(window(0));
        a1   = two_over(window(s + 1));
        p1   = (bmjs_pkg::Q15_ONE - p) * a0;
        p12  = p1 + (bmjs_pkg::Q15_ONE - p) * (bmjs_pkg::Q15_ONE - a0);
        p123 = p12 + p * a1;
        c.push_back(up_div(p1));
        c.push_back(up_div(p12));
        c.push_back(up_div(p123));
      end else if (s == NUM_STAGES) begin
        c.push_back(two_over(window(0)));
      end else if (s <= TOP_STATE) begin
        w = window(s - BACKOFF0);
        c.push_back((w == 0) ? bmjs_pkg::Q15_ONE : two_over(w - 1));
      end
      c.push_back(bmjs_pkg::Q15_ONE);
    endfunction

    function bmjs_pkg::res_t chain_step(logic [bmjs_pkg::RAND_W-1:0] r);
      int             c[$];
      int             k;
      int             s;
      int             nxt;
      logic [1:0]     kind;
      bmjs_pkg::res_t res;
      draw_cuts(c);
      s    = int'(chain);
      k    = 0;
      nxt  = 0;
      kind = bmjs_pkg::KIND_NONE;
      while (int'(r) >= c[k+1]) k++;
      if (s < NUM_STAGES) begin
        case (k)
          PATH_TX:      begin nxt = 0;                kind = bmjs_pkg::KIND_SUCC; end
          PATH_BO:      begin nxt = BACKOFF0;         kind = bmjs_pkg::KIND_SUCC; end
          PATH_TX_NEXT: begin nxt = s + 1;            kind = bmjs_pkg::KIND_COLL; end
          default:      begin nxt = BACKOFF0 + s + 1; kind = bmjs_pkg::KIND_COLL; end
        endcase
      end else if (s == NUM_STAGES) begin
        nxt  = (k == PATH_TX) ? 0 : BACKOFF0;
        kind = bmjs_pkg::KIND_COLL;
      end else if (s <= TOP_STATE) begin
        nxt  = (k == PATH_TX) ? s - BACKOFF0 : s;
        kind = bmjs_pkg::KIND_BOFF;
      end
      res = '0;
      case (kind)
        bmjs_pkg::KIND_SUCC: begin
          res.jammer_on  = 1'b1;
          res.first_hold = cfg.success_hold;
          jam_active     = 1'b1;
        end
        bmjs_pkg::KIND_COLL: begin
          res.jammer_on      = 1'b1;
          res.first_hold     = cfg.collision_hold;
          res.turn_off_after = 1'b1;
          res.second_hold    = cfg.eifs_gap;
          jam_active         = 1'b0;
        end
        bmjs_pkg::KIND_BOFF: begin
          res.first_hold = cfg.slot_hold;
          jam_active     = 1'b0;
        end
        default: jam_active = 1'b0;
      endcase
      chain = bmjs_pkg::STATE_W'(nxt);
      res.next_chain_state = chain;
      return res;
    endfunction

    // a draw that takes the wanted branch of the current state when it can
    function int pick_draw(int path, int mode);
      int c[$];
      int k;
      int lo;
      int hi;
      draw_cuts(c);
      if (path < 0 || path >= c.size() - 1 || c[path+1] <= c[path]) begin
        do k = $urandom_range(0, c.size() - 2); while (c[k+1] <= c[k]);
      end else begin
        k = path;
      end
      lo = c[k];
      hi = c[k+1] - 1;
      case (mode)
        PICK_LOW:  return lo;
        PICK_HIGH: return hi;
        default:   return $urandom_range(lo, hi);
      endcase
    endfunction

    function void note_input(logic [bmjs_pkg::RAND_W-1:0] r);
      expected_steps.push_back(chain_step(r));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(bmjs_pkg::res_t got);
      bmjs_pkg::res_t want;
      if (expected_steps.size() == 0) begin
        report($sformatf("result beat with no step pending, state %0d",
                         got.next_chain_state));
      end else begin
        want = expected_steps.pop_front();
        if (got.next_chain_state !== want.next_chain_state)
          report($sformatf("next_chain_state got %0d want %0d",
                           got.next_chain_state, want.next_chain_state));
        if (got.jammer_on !== want.jammer_on)
          report($sformatf("jammer_on got %0b want %0b", got.jammer_on, want.jammer_on));
        if (got.first_hold !== want.first_hold)
          report($sformatf("first_hold got %0d want %0d", got.first_hold, want.first_hold));
        if (got.turn_off_after !== want.turn_off_after)
          report($sformatf("turn_off_after got %0b want %0b",
                           got.turn_off_after, want.turn_off_after));
        if (got.second_hold !== want.second_hold)
          report($sformatf("second_hold got %0d want %0d",
                           got.second_hold, want.second_hold));
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [bmjs_pkg::RAND_W-1:0]    in_rand_value = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [bmjs_pkg::STATE_W-1:0]   out_next_chain_state;
  logic                           out_jammer_on;
  logic [bmjs_pkg::CFG_W-1:0]     out_first_hold;
  logic                           out_turn_off_after;
  logic [bmjs_pkg::CFG_W-1:0]     out_second_hold;
  logic                           cfg_we = 1'b0;
  logic [bmjs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bmjs_pkg::CFG_W-1:0]     cfg_data = '0;

  jammer_scoreboard sb;
  bit               idle_on = 1'b1;
  int               stall_left = 0;
  int               gap_pick;
  bmjs_pkg::res_t   seen;

  backoff_markov_jammer_sequencer #(
    .STAGES      (NUM_STAGES),
    .WINDOW_BASE (WIN_BASE),
    .WINDOW_MAX  (WIN_MAX)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rand_value        (in_rand_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_next_chain_state (out_next_chain_state),
    .out_jammer_on        (out_jammer_on),
    .out_first_hold       (out_first_hold),
    .out_turn_off_after   (out_turn_off_after),
    .out_second_hold      (out_second_hold),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int idle_gap();
    int pct;
    if (!idle_on) return 0;
    pct = $urandom_range(0, 99);
    if (pct < 65) return 0;
    if (pct < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // result side: check accepted beats, then stall in bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.next_chain_state = out_next_chain_state;
      seen.jammer_on        = out_jammer_on;
      seen.first_hold       = out_first_hold;
      seen.turn_off_after   = out_turn_off_after;
      seen.second_hold      = out_second_hold;
      sb.check_result(seen);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      gap_pick = ($urandom_range(0, 2) == 0) ? idle_gap() : 0;
      out_stall <= (gap_pick > 0);
      stall_left = (gap_pick > 0) ? gap_pick - 1 : 0;
    end
  end

  task automatic send_beat(input logic [bmjs_pkg::RAND_W-1:0] r);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_rand_value <= r;
    do @(posedge clk); while (in_stall);
    sb.note_input(r);
  endtask

  task automatic run_steps(input int n);
    int m;
    int mode;
    repeat (n) begin
      m    = $urandom_range(0, 5);
      mode = (m < 4) ? PICK_ANY : ((m == 4) ? PICK_LOW : PICK_HIGH);
      if ($urandom_range(0, 3) != 0)
        send_beat(bmjs_pkg::RAND_W'(sb.pick_draw(PATH_ANY, mode)));
      else
        send_beat(bmjs_pkg::RAND_W'($urandom_range(0, bmjs_pkg::Q15_ONE - 1)));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_steps.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bmjs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bmjs_pkg::CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic load_settings(input bmjs_pkg::cfg_t c);
    logic [bmjs_pkg::CFG_IDX_W-1:0] stray;
    stray = bmjs_pkg::CFG_IDX_W'(bmjs_pkg::REG_SLOT_HOLD + 1 + $urandom_range(0, 2));
    wait_idle();
    write_reg(stray, bmjs_pkg::CFG_W'($urandom_range(0, 16'hffff)));
    write_reg(bmjs_pkg::REG_COLL_PROB, c.collision_prob_q15);
    write_reg(bmjs_pkg::REG_SUCC_HOLD, c.success_hold);
    write_reg(bmjs_pkg::REG_COLL_HOLD, c.collision_hold);
    write_reg(bmjs_pkg::REG_EIFS_GAP, c.eifs_gap);
    write_reg(bmjs_pkg::REG_SLOT_HOLD, c.slot_hold);
    cfg_we <= 1'b0;
  endtask

  function automatic bmjs_pkg::cfg_t make_cfg(int p, int sh, int ch, int eg, int sl);
    bmjs_pkg::cfg_t c;
    c.collision_prob_q15 = bmjs_pkg::CFG_W'(p);
    c.success_hold       = bmjs_pkg::CFG_W'(sh);
    c.collision_hold     = bmjs_pkg::CFG_W'(ch);
    c.eifs_gap           = bmjs_pkg::CFG_W'(eg);
    c.slot_hold          = bmjs_pkg::CFG_W'(sl);
    return c;
  endfunction

  function automatic bmjs_pkg::cfg_t random_cfg(int p);
    return make_cfg(p, $urandom_range(0, 16'hffff), $urandom_range(0, 16'hffff),
                    $urandom_range(0, 16'hffff), $urandom_range(0, 16'hffff));
  endfunction

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int n;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, then climb the transmit stages to the last one
    send_beat('0);
    send_beat('1);
    send_beat(bmjs_pkg::RAND_W'(sb.pick_draw(PATH_TX, PICK_LOW)));
    n = 0;
    while (sb.chain != NUM_STAGES && n < 12) begin
      send_beat(bmjs_pkg::RAND_W'(sb.pick_draw(PATH_TX_NEXT,
                                               (n % 2) ? PICK_HIGH : PICK_LOW)));
      n++;
    end
    send_beat(bmjs_pkg::RAND_W'(sb.pick_draw(PATH_BO, PICK_HIGH)));
    send_beat(bmjs_pkg::RAND_W'(sb.pick_draw(PATH_TX, PICK_LOW)));
    send_beat(bmjs_pkg::RAND_W'(sb.pick_draw(PATH_BO_NEXT, PICK_HIGH)));
    send_beat(bmjs_pkg::RAND_W'(sb.pick_draw(PATH_BO, PICK_LOW)));
    send_beat(bmjs_pkg::RAND_W'(sb.pick_draw(PATH_TX, PICK_HIGH)));
    send_beat(bmjs_pkg::RAND_W'(sb.pick_draw(PATH_TX_NEXT, PICK_LOW)));
    run_steps(60);

    load_settings(make_cfg(0, 0, 0, 0, 0));
    run_steps(70);

    // certain collision with the longest holds, no idling
    idle_on = 1'b0;
    load_settings(make_cfg(bmjs_pkg::Q15_ONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    run_steps(70);
    idle_on = 1'b1;

    // probability above one saturates
    load_settings(random_cfg(16'hffff));
    run_steps(70);

    load_settings(random_cfg($urandom_range(0, bmjs_pkg::Q15_ONE)));
    run_steps(80);

    idle_on = 1'b0;
    load_settings(random_cfg($urandom_range(bmjs_pkg::Q15_ONE / 2, bmjs_pkg::Q15_ONE)));
    run_steps(80);
    idle_on = 1'b1;

    load_settings(random_cfg($urandom_range(0, 16'hffff)));
    run_steps(80);

    wait_idle();
    repeat (2 * LAT_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bmjs_pkg.sv
sv/bmjs_cfg.sv
sv/bmjs_step.sv
sv/backoff_markov_jammer_sequencer.sv
bench/backoff_markov_jammer_sequencer_test.sv
